@@ hdl/tbc_pkg.sv @@
// Package for the 32-bit toy block cipher: byte helpers, subkey schedule
// and the full encrypt / decrypt functions. No dependencies.
package tbc_pkg;

  localparam int unsigned Rounds    = 8;
  localparam int unsigned BlockBits = 32;
  localparam logic [7:0]  RoundMask = 8'hAA;

  // Operation codes carried on the input tuser bit
  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } cmd_e;

  typedef logic [BlockBits-1:0] block_t;

  // Byte i of a word sits at bits 31-8i down to 24-8i
  function automatic logic [7:0] get_byte(input block_t w, input int unsigned i);
    return w[31 - 8*i -: 8];
  endfunction

  // Rotate a byte left by n bits
  function automatic logic [7:0] rotl8(input logic [7:0] v, input logic [2:0] n);
    logic [15:0] dbl;
    dbl = {v, v} << n;
    return dbl[15:8];
  endfunction

  // Subkey of round r: rotated key byte, XOR constant, bit rotate
  function automatic block_t subkey(input block_t key, input int unsigned r);
    block_t     sk;
    logic [7:0] v;
    logic [7:0] c;
    for (int unsigned i = 0; i < 4; i++) begin
      c = 8'((r * 17 + i * 3) & 8'hFF);
      v = get_byte(key, (i + r) % 4) ^ c;
      sk[31 - 8*i -: 8] = rotl8(v, 3'((r % 7) + 1));
    end
    return sk;
  endfunction

  // Swap byte 0 with 1 and byte 2 with 3
  function automatic block_t swap_pairs(input block_t b);
    return {b[23:16], b[31:24], b[7:0], b[15:8]};
  endfunction

  function automatic block_t encrypt(input block_t blk, input block_t key);
    block_t     b;
    block_t     sk;
    logic [7:0] v;
    b = blk;
    for (int unsigned r = 0; r < Rounds; r++) begin
      sk = subkey(key, r);
      for (int unsigned i = 0; i < 4; i++) begin
        v = get_byte(b, i) ^ get_byte(sk, i) ^ RoundMask;
        // left by 1 then by 3 is a nibble swap
        b[31 - 8*i -: 8] = {v[3:0], v[7:4]};
      end
      b = swap_pairs(b);
    end
    return b;
  endfunction

  function automatic block_t decrypt(input block_t blk, input block_t key);
    block_t     b;
    block_t     sk;
    logic [7:0] v;
    b = blk;
    for (int r = Rounds - 1; r >= 0; r--) begin
      sk = subkey(key, unsigned'(r));
      b  = swap_pairs(b);
      for (int unsigned i = 0; i < 4; i++) begin
        v = get_byte(b, i);
        b[31 - 8*i -: 8] = {v[3:0], v[7:4]} ^ RoundMask ^ get_byte(sk, i);
      end
    end
    return b;
  endfunction

endpackage

@@ hdl/toy_32bit_block_cipher.sv @@
// Top level of the 32-bit toy block cipher: input register, 8-round
// combinational datapath, output register. Depends on tbc_pkg.

// Encrypts or decrypts one 32-bit word per cycle, while m_axis_tready
// holds, with the key held in the configuration register (byte 0 in bits
// 31:24). A word is captured in the input register, passes all eight
// rounds in combinational XOR and byte rotate logic, and lands in the
// output register. tvalid rises once the word has moved on from the input
// register into the output register, which a stalled output can hold back.
// The input side stays ready while a result waits, as long as the input
// register can move on. Write the key only while no word is in flight.
module toy_32bit_block_cipher
  import tbc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // key register
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] data_in
  input  logic        s_axis_tuser,   // [0] cmd (0 encrypt, 1 decrypt)
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [31:0] data_out
);

  block_t key_q;
  logic   in_valid_q;
  cmd_e   in_cmd_q;
  block_t in_data_q;
  logic   out_valid_q;
  block_t out_data_q;
  block_t result;
  logic   out_load;
  logic   in_load;

  // Key register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q <= cfg_wdata_i;
    end
  end

  // Handshake: output register frees when empty or taken
  assign out_load      = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || out_load;
  assign in_load       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_cmd_q  <= cmd_e'(s_axis_tuser);
      in_data_q <= s_axis_tdata;
    end
  end

  // Round datapath
  always_comb begin
    case (in_cmd_q)
      CMD_DECRYPT: result = decrypt(in_data_q, key_q);
      default:     result = encrypt(in_data_q, key_q);
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Checks
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_load |=> in_valid_q)
    else $error("accepted word not held in input register");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_load) |=> (in_valid_q && $stable(in_data_q)))
    else $error("stalled input register lost its word");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
    else $error("input ready while both registers are blocked");

  a_out_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && out_data_q == $past(result)))
    else $error("output register did not take the round result");

endmodule
